@@ hdl/msws_pkg.sv @@
package msws_pkg;

	localparam int MASK_W     = 4;
	localparam int THR_W      = 16;
	localparam int MODE_W     = 2;
	localparam int CODE_W     = 3;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int NUM_SOURCES_DEF = 4;
	localparam int AGE_BITS_DEF    = 16;

	localparam logic [THR_W-1:0]  WARNING_RST  = THR_W'(10);
	localparam logic [THR_W-1:0]  FAULT_RST    = THR_W'(20);
	localparam logic [THR_W-1:0]  SUPPRESS_RST = THR_W'(40);
	localparam logic [MASK_W-1:0] ENABLE_RST   = '0;

	// register map
	localparam logic [CFG_IDX_W-1:0] CFG_WARNING  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT    = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SUPPRESS = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = CFG_IDX_W'(3);

	localparam logic [MODE_W-1:0] MODE_OTHER = MODE_W'(0);

	typedef enum logic [CODE_W-1:0] {
		ST_DISABLED = 3'd0,
		ST_HEALTHY  = 3'd1,
		ST_WARNING  = 3'd2,
		ST_FAULT    = 3'd3,
		ST_SUPPRESS = 3'd4
	} src_state_t;

	typedef enum logic [CODE_W-1:0] {
		LV_NONE     = 3'd0,
		LV_WARNING  = 3'd1,
		LV_FAULT    = 3'd2,
		LV_SAFE     = 3'd3,
		LV_SUPPRESS = 3'd4
	} level_t;

	// what one lane found this tick
	typedef struct packed {
		logic enabled;
		logic warn;
		logic fault;
		logic supp;
		logic cross_warn;
		logic cross_fault;
		logic cross_supp;
		logic recovered;
	} lane_flags_t;

	typedef struct packed {
		logic [MASK_W-1:0] warning_mask;
		logic [MASK_W-1:0] fault_mask;
		logic [MASK_W-1:0] suppress_mask;
		logic [MASK_W-1:0] crossed_warning_mask;
		logic [MASK_W-1:0] crossed_fault_mask;
		logic [MASK_W-1:0] crossed_suppress_mask;
		logic [MASK_W-1:0] recovered_mask;
		logic              safe_request;
		src_state_t        aggregate_state;
		level_t            recovery_level;
		logic              feed_eligible;
		logic              config_valid;
	} result_t;

endpackage

@@ hdl/msws_if.sv @@
interface msws_tick_if;
	logic                          valid;
	logic                          ready;
	logic [msws_pkg::MASK_W-1:0]   beat_mask;
	logic [msws_pkg::MODE_W-1:0]   sat_mode;
	logic                          safe_already_requested;

	modport source(output valid, beat_mask, sat_mode, safe_already_requested, input ready);
	modport sink(input valid, beat_mask, sat_mode, safe_already_requested, output ready);
endinterface

interface msws_result_if;
	logic                          valid;
	logic                          ready;
	logic [msws_pkg::MASK_W-1:0]   warning_mask;
	logic [msws_pkg::MASK_W-1:0]   fault_mask;
	logic [msws_pkg::MASK_W-1:0]   suppress_mask;
	logic [msws_pkg::MASK_W-1:0]   crossed_warning_mask;
	logic [msws_pkg::MASK_W-1:0]   crossed_fault_mask;
	logic [msws_pkg::MASK_W-1:0]   crossed_suppress_mask;
	logic [msws_pkg::MASK_W-1:0]   recovered_mask;
	logic                          safe_request;
	logic [msws_pkg::CODE_W-1:0]   aggregate_state;
	logic [msws_pkg::CODE_W-1:0]   recovery_level;
	logic                          feed_eligible;
	logic                          config_valid;

	modport source(output valid, warning_mask, fault_mask, suppress_mask,
		crossed_warning_mask, crossed_fault_mask, crossed_suppress_mask,
		recovered_mask, safe_request, aggregate_state, recovery_level,
		feed_eligible, config_valid, input ready);
	modport sink(input valid, warning_mask, fault_mask, suppress_mask,
		crossed_warning_mask, crossed_fault_mask, crossed_suppress_mask,
		recovered_mask, safe_request, aggregate_state, recovery_level,
		feed_eligible, config_valid, output ready);
endinterface

interface msws_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [msws_pkg::CFG_IDX_W-1:0]  index;
	logic [msws_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/msws_lane.sv @@
module msws_lane #(
	parameter int AGE_BITS = msws_pkg::AGE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic                         en,
	input  logic                         beat,
	input  logic [msws_pkg::THR_W-1:0]   warning_ticks,
	input  logic [msws_pkg::THR_W-1:0]   fault_ticks,
	input  logic [msws_pkg::THR_W-1:0]   suppress_ticks,
	output msws_pkg::lane_flags_t        flags
);

	localparam int CMP_W = (AGE_BITS > msws_pkg::THR_W) ? AGE_BITS : msws_pkg::THR_W;

	logic [AGE_BITS-1:0]  age_q;
	logic [AGE_BITS-1:0]  age_next;
	msws_pkg::src_state_t state_q;
	msws_pkg::src_state_t state_next;
	msws_pkg::src_state_t cls;
	logic [CMP_W-1:0]     age_x;
	logic                 prev_above_healthy;

	always_comb begin
		if (beat) begin
			age_next = '0;
		end else if (age_q != '1) begin
			age_next = age_q + AGE_BITS'(1);
		end else begin
			age_next = age_q;
		end
		age_x = CMP_W'(age_next);

		// suppress checked first so inconsistent thresholds still resolve
		priority if (age_x >= CMP_W'(suppress_ticks)) begin
			cls = msws_pkg::ST_SUPPRESS;
		end else if (age_x >= CMP_W'(fault_ticks)) begin
			cls = msws_pkg::ST_FAULT;
		end else if (age_x >= CMP_W'(warning_ticks)) begin
			cls = msws_pkg::ST_WARNING;
		end else begin
			cls = msws_pkg::ST_HEALTHY;
		end

		state_next = en ? cls : msws_pkg::ST_DISABLED;
		prev_above_healthy = (state_q > msws_pkg::ST_HEALTHY);

		flags.enabled     = en;
		flags.warn        = en && (cls == msws_pkg::ST_WARNING);
		flags.fault       = en && (cls == msws_pkg::ST_FAULT || cls == msws_pkg::ST_SUPPRESS);
		flags.supp        = en && (cls == msws_pkg::ST_SUPPRESS);
		flags.cross_warn  = en && !beat && (state_q < msws_pkg::ST_WARNING)
			&& (cls >= msws_pkg::ST_WARNING);
		flags.cross_fault = en && !beat && (state_q < msws_pkg::ST_FAULT)
			&& (cls >= msws_pkg::ST_FAULT);
		flags.cross_supp  = en && !beat && (state_q != msws_pkg::ST_SUPPRESS)
			&& (cls == msws_pkg::ST_SUPPRESS);
		flags.recovered   = prev_above_healthy && (!en || beat);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q   <= '0;
			state_q <= msws_pkg::ST_DISABLED;
		end else if (advance) begin
			age_q   <= en ? age_next : '0;
			state_q <= state_next;
		end
	end

	a_disabled_age_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msws_pkg::ST_DISABLED |-> age_q == '0)
		else $error("disabled lane holds nonzero age");

	a_beat_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && en && beat |=> age_q == '0 && state_q != msws_pkg::ST_DISABLED)
		else $error("beat did not clear age");

	a_off_disables: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !en |=> state_q == msws_pkg::ST_DISABLED)
		else $error("disabled source kept a live state");

endmodule

@@ hdl/msws_merge.sv @@
module msws_merge #(
	parameter int NUM_SOURCES = msws_pkg::NUM_SOURCES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  msws_pkg::lane_flags_t         flags [NUM_SOURCES],
	input  logic [msws_pkg::MODE_W-1:0]   sat_mode,
	input  logic                          already,
	input  logic                          cfg_ok,
	output logic                          accept_ok,
	output logic                          out_valid,
	input  logic                          out_ready,
	output msws_pkg::result_t             out_data
);

	localparam int MW = msws_pkg::MASK_W;

	msws_pkg::result_t res;
	msws_pkg::result_t main_q;
	msws_pkg::result_t skid_q;
	logic              main_v_q;
	logic              skid_v_q;
	logic              any_en;
	logic              pop;

	always_comb begin
		res = '0;
		any_en = 1'b0;
		for (int j = 0; j < NUM_SOURCES; j++) begin
			any_en = any_en | flags[j].enabled;
			// lanes past the mask width have no enable bit, so shifting them out is safe
			res.warning_mask          = res.warning_mask | (MW'(flags[j].warn) << j);
			res.fault_mask            = res.fault_mask | (MW'(flags[j].fault) << j);
			res.suppress_mask         = res.suppress_mask | (MW'(flags[j].supp) << j);
			res.crossed_warning_mask  = res.crossed_warning_mask
				| (MW'(flags[j].cross_warn) << j);
			res.crossed_fault_mask    = res.crossed_fault_mask
				| (MW'(flags[j].cross_fault) << j);
			res.crossed_suppress_mask = res.crossed_suppress_mask
				| (MW'(flags[j].cross_supp) << j);
			res.recovered_mask        = res.recovered_mask | (MW'(flags[j].recovered) << j);
		end
		res.safe_request = (res.crossed_fault_mask != '0) && (sat_mode != msws_pkg::MODE_OTHER);
		res.config_valid = cfg_ok;

		priority if (!any_en) begin
			res.aggregate_state = msws_pkg::ST_DISABLED;
			res.recovery_level  = msws_pkg::LV_NONE;
			res.feed_eligible   = 1'b0;
		end else if (res.suppress_mask != '0) begin
			res.aggregate_state = msws_pkg::ST_SUPPRESS;
			res.recovery_level  = msws_pkg::LV_SUPPRESS;
			res.feed_eligible   = 1'b0;
		end else if (res.fault_mask != '0) begin
			res.aggregate_state = msws_pkg::ST_FAULT;
			res.recovery_level  = already ? msws_pkg::LV_SAFE : msws_pkg::LV_FAULT;
			res.feed_eligible   = 1'b1;
		end else if (res.warning_mask != '0) begin
			res.aggregate_state = msws_pkg::ST_WARNING;
			res.recovery_level  = msws_pkg::LV_WARNING;
			res.feed_eligible   = 1'b1;
		end else begin
			res.aggregate_state = msws_pkg::ST_HEALTHY;
			res.recovery_level  = msws_pkg::LV_NONE;
			res.feed_eligible   = 1'b1;
		end
	end

	// output register plus one skid entry; new beats are taken until the skid fills
	assign accept_ok = !skid_v_q;
	assign pop       = main_v_q && out_ready;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				if (!main_v_q || pop) begin
					main_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= 1'b0;
				end else begin
					main_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && (!main_v_q || pop)) begin
			main_q <= res;
		end else if (push) begin
			skid_q <= res;
		end else if (pop && skid_v_q) begin
			main_q <= skid_q;
		end
	end

	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry without head entry");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		push && main_v_q && !out_ready |=> skid_v_q)
		else $error("stalled beat not parked in skid");

	a_safe_has_cross: assert property (@(posedge clk) disable iff (!arst_n)
		main_v_q && main_q.safe_request |-> main_q.crossed_fault_mask != '0)
		else $error("safe request without fault crossing");

endmodule

@@ hdl/multi_source_watchdog_supervisor.sv @@
// channel   dir   handshake        payload
// tick      in    valid / ready    beat_mask, sat_mode, safe_already_requested
// result    out   valid / ready    masks, safe_request, aggregate/recovery codes, flags
// cfg       in    valid / ready    index (register number), data
//
// One tick per cycle while tick.ready is high; results are registered on acceptance.
// Per-source age and state update in the lanes at acceptance; the merge is combinational.
// Output register plus one skid entry: tick.ready drops only with two results waiting.
// arst_n clears ages, states, valid flags and loads the register reset values.
// cfg is always ready; a write to an index beyond the map is dropped.
module multi_source_watchdog_supervisor #(
	parameter int NUM_SOURCES = msws_pkg::NUM_SOURCES_DEF,
	parameter int AGE_BITS    = msws_pkg::AGE_BITS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	msws_tick_if.sink          tick,
	msws_result_if.source      result,
	msws_cfg_if.sink           cfg
);

	logic [msws_pkg::THR_W-1:0]  warning_q;
	logic [msws_pkg::THR_W-1:0]  fault_q;
	logic [msws_pkg::THR_W-1:0]  suppress_q;
	logic [msws_pkg::MASK_W-1:0] enable_q;
	logic                        cfg_ok;
	logic                        accept_ok;
	logic                        advance;
	msws_pkg::lane_flags_t       flags [NUM_SOURCES];
	msws_pkg::result_t           res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warning_q  <= msws_pkg::WARNING_RST;
			fault_q    <= msws_pkg::FAULT_RST;
			suppress_q <= msws_pkg::SUPPRESS_RST;
			enable_q   <= msws_pkg::ENABLE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				msws_pkg::CFG_WARNING:  warning_q  <= cfg.data;
				msws_pkg::CFG_FAULT:    fault_q    <= cfg.data;
				msws_pkg::CFG_SUPPRESS: suppress_q <= cfg.data;
				msws_pkg::CFG_ENABLE:   enable_q   <= cfg.data[msws_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ok = (warning_q != '0) && (warning_q <= fault_q) && (fault_q <= suppress_q);

	assign tick.ready = accept_ok;
	assign advance    = tick.valid && accept_ok;

	for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_lane
		logic en_i;
		logic beat_i;
		if (i < msws_pkg::MASK_W) begin : g_bit
			assign en_i   = enable_q[i];
			assign beat_i = tick.beat_mask[i];
		end else begin : g_none
			assign en_i   = 1'b0;
			assign beat_i = 1'b0;
		end

		msws_lane #(
			.AGE_BITS(AGE_BITS)
		) u_lane (
			.clk            (clk),
			.arst_n         (arst_n),
			.advance        (advance),
			.en             (en_i),
			.beat           (beat_i),
			.warning_ticks  (warning_q),
			.fault_ticks    (fault_q),
			.suppress_ticks (suppress_q),
			.flags          (flags[i])
		);
	end

	msws_merge #(
		.NUM_SOURCES(NUM_SOURCES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.flags     (flags),
		.sat_mode  (tick.sat_mode),
		.already   (tick.safe_already_requested),
		.cfg_ok    (cfg_ok),
		.accept_ok (accept_ok),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res)
	);

	assign result.warning_mask          = res.warning_mask;
	assign result.fault_mask            = res.fault_mask;
	assign result.suppress_mask         = res.suppress_mask;
	assign result.crossed_warning_mask  = res.crossed_warning_mask;
	assign result.crossed_fault_mask    = res.crossed_fault_mask;
	assign result.crossed_suppress_mask = res.crossed_suppress_mask;
	assign result.recovered_mask        = res.recovered_mask;
	assign result.safe_request          = res.safe_request;
	assign result.aggregate_state       = res.aggregate_state;
	assign result.recovery_level        = res.recovery_level;
	assign result.feed_eligible         = res.feed_eligible;
	assign result.config_valid          = res.config_valid;

endmodule
